>>> rtl/core/nsfp_pkg.sv
// Shared types, codes and arithmetic helpers of the NMEA sentence field parser.
`default_nettype none
package nsfp_pkg;

  localparam int unsigned MagW             = 40;
  localparam int unsigned MaxFracDigitsDef = 7;
  localparam int unsigned ValueBitsDef     = 41;
  localparam int unsigned QueueDepth       = 2;
  localparam logic [63:0] DecLimit         = 64'd999999999999;

  typedef enum logic [2:0] {
    QTY_TIME    = 3'd0,
    QTY_DATE    = 3'd1,
    QTY_LAT     = 3'd2,
    QTY_NS      = 3'd3,
    QTY_LON     = 3'd4,
    QTY_EW      = 3'd5,
    QTY_FIX     = 3'd6,
    QTY_HEADING = 3'd7
  } qty_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_GGA  = 2'd2,
    KIND_TRA  = 2'd3
  } kind_e;

  // One field request handed from the front to the back.
  typedef struct packed {
    qty_e            qty;
    logic [MagW-1:0] mag;
    logic            neg;
    logic [2:0]      scale;
    logic [2:0]      frac;
    logic [6:0]      hi;
    logic [6:0]      mid;
    logic [6:0]      lo;
  } entry_t;

  // Saturating mag*10+add; the result is never above lim.
  function automatic logic [MagW-1:0] sat_mac10(input logic [MagW-1:0] mag,
                                                input logic [3:0] add,
                                                input logic [MagW-1:0] lim);
    logic [MagW+3:0] p;
    p = {mag, 3'b000} + {2'b00, mag, 1'b0} + {(MagW)'(0), add};
    sat_mac10 = (p > {4'd0, lim}) ? lim : p[MagW-1:0];
  endfunction

  function automatic logic [MagW-1:0] value_limit(input int unsigned vbits);
    logic [63:0] l;
    l = (64'd1 << (vbits - 1)) - 64'd1;
    value_limit = (l < DecLimit) ? l[MagW-1:0] : DecLimit[MagW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/nmea_sentence_field_parser.sv
// Top level of the NMEA sentence field parser.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  text in  | in        | push / full        | text_byte_i
//  results  | out       | empty / pop        | quantity_o, value_o, fraction_digits_o,
//           |           |                    | part_high_o, part_mid_o, part_low_o
//
// One byte is taken every cycle while push is high and full is low. A result passes
// through the request queue and the back end's working register into the output
// register; latitude and longitude also pass the back end's multiply-by-ten step.
// full rises when the two-entry request queue holds two requests. Reset clears all
// control state; no clearing pass follows it.
`default_nettype none
module nmea_sentence_field_parser #(
  parameter int unsigned MAX_FRACTION_DIGITS = nsfp_pkg::MaxFracDigitsDef,
  parameter int unsigned VALUE_BITS          = nsfp_pkg::ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            text_byte_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [2:0]                 quantity_o,
  output logic [VALUE_BITS-1:0]      value_o,
  output logic [2:0]                 fraction_digits_o,
  output logic [6:0]                 part_high_o,
  output logic [6:0]                 part_mid_o,
  output logic [6:0]                 part_low_o
);
  import nsfp_pkg::*;

  logic   accept;
  logic   fr_push;
  entry_t fr_entry;
  logic   q_valid, q_take;
  entry_t q_data;

  assign accept = push && !full;

  nsfp_front #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
    .VALUE_BITS         (VALUE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .byte_i (text_byte_i),
    .push_o (fr_push),
    .entry_o(fr_entry)
  );

  nsfp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (fr_push),
    .wr_data_i(fr_entry),
    .full_o   (full),
    .rd_i     (q_take),
    .valid_o  (q_valid),
    .rd_data_o(q_data)
  );

  nsfp_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (q_valid),
    .req_i            (q_data),
    .req_take_o       (q_take),
    .pop_i            (pop),
    .empty_o          (empty),
    .quantity_o       (quantity_o),
    .value_o          (value_o),
    .fraction_digits_o(fraction_digits_o),
    .part_high_o      (part_high_o),
    .part_mid_o       (part_mid_o),
    .part_low_o       (part_low_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/nsfp_front.sv
// Front end: header matching, field counting and number accumulation per byte.
`default_nettype none
module nsfp_front #(
  parameter int unsigned MAX_FRACTION_DIGITS = nsfp_pkg::MaxFracDigitsDef,
  parameter int unsigned VALUE_BITS          = nsfp_pkg::ValueBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [7:0]      byte_i,
  output logic                 push_o,
  output nsfp_pkg::entry_t     entry_o
);
  import nsfp_pkg::*;

  localparam logic [MagW-1:0] Lim       = value_limit(VALUE_BITS);
  localparam logic [2:0]      HdrIdle   = 3'd0;
  localparam logic [2:0]      HdrFirst  = 3'd1;
  localparam logic [2:0]      HdrKind   = 3'd3;
  localparam logic [2:0]      HdrActive = 3'd6;
  localparam logic [3:0]      LatLonCap = 4'd7;
  localparam logic [3:0]      FracCap   = 4'(MAX_FRACTION_DIGITS);

  // Saturated value split per fraction count, worked out at elaboration.
  logic [MagW-1:0] lt_val [16];
  logic [6:0]      lt_hi  [16];
  logic [6:0]      lt_mid [16];
  logic [6:0]      lt_lo  [16];

  for (genvar k = 0; k < 16; k++) begin : g_lt
    localparam logic [63:0] TV  = {24'd0, Lim} / (64'd10 ** k);
    localparam logic [63:0] THI = TV / 64'd10000;
    assign lt_val[k] = TV[MagW-1:0];
    assign lt_hi[k]  = (THI > 64'd99) ? 7'd99 : THI[6:0];
    assign lt_mid[k] = 7'((TV / 64'd100) % 64'd100);
    assign lt_lo[k]  = 7'(TV % 64'd100);
  end

  logic [2:0]      hdr_q, hdr_d;
  kind_e           kind_q, kind_d;
  logic [4:0]      field_q, field_d;
  logic [MagW-1:0] acc_q, acc_d;
  logic [MagW-1:0] int_q, int_d;
  logic [3:0]      fdc_q, fdc_d;
  logic            neg_q, neg_d, dot_q, dot_d, ill_q, ill_d;
  logic [7:0]      ffc_q, ffc_d;
  logic [23:0]     bcd_q, bcd_d;
  logic            big_q, big_d;

  logic            want_v;
  qty_e            want_qty;
  logic            term, ok, fin, ill_end;
  logic [3:0]      cap;
  logic            ill;
  logic [3:0]      fdc_e;
  logic [MagW-1:0] mag_e, t_val;
  logic            sat;
  logic [6:0]      b_hi, b_mid, b_lo;

  always_comb begin
    want_v   = 1'b0;
    want_qty = QTY_TIME;
    unique case (kind_q)
      KIND_RMC: begin
        if (field_q == 5'd1) begin
          want_v = 1'b1; want_qty = QTY_TIME;
        end else if (field_q == 5'd9) begin
          want_v = 1'b1; want_qty = QTY_DATE;
        end
      end
      KIND_GGA: begin
        if (field_q >= 5'd2 && field_q <= 5'd6) begin
          want_v = 1'b1; want_qty = qty_e'(field_q[2:0]);
        end
      end
      KIND_TRA: begin
        if (field_q == 5'd2) begin
          want_v = 1'b1; want_qty = QTY_HEADING;
        end
      end
      default: ;
    endcase
  end

  assign cap  = (want_qty == QTY_LAT || want_qty == QTY_LON) ? LatLonCap : FracCap;
  assign term = (byte_i == "*") || (byte_i < 8'h20) || (byte_i > "z");

  always_comb begin
    unique case (hdr_q)
      3'd1:    ok = (byte_i == "G");
      3'd2:    ok = (byte_i == "P");
      3'd3:    ok = (byte_i == "R") || (byte_i == "G") || (byte_i == "T");
      3'd4:    ok = (kind_q == KIND_RMC && byte_i == "M") ||
                    (kind_q == KIND_GGA && byte_i == "G") ||
                    (kind_q == KIND_TRA && byte_i == "R");
      default: ok = (kind_q == KIND_RMC && byte_i == "C") ||
                    (kind_q == KIND_GGA && byte_i == "A") ||
                    (kind_q == KIND_TRA && byte_i == "A");
    endcase
  end

  // Field close: build the request.
  assign ill_end = term && (byte_i != "*");
  assign ill     = ill_q || (ill_end && byte_i != ",");
  assign fdc_e   = ill ? 4'd0 : fdc_q;
  assign mag_e   = ill ? '0 : acc_q;
  assign sat     = (mag_e == Lim);
  assign b_hi    = big_q ? 7'd99 : (7'(bcd_q[23:20]) * 7'd10 + 7'(bcd_q[19:16]));
  assign b_mid   = 7'(bcd_q[15:12]) * 7'd10 + 7'(bcd_q[11:8]);
  assign b_lo    = 7'(bcd_q[7:4]) * 7'd10 + 7'(bcd_q[3:0]);

  always_comb begin
    if (ill)      t_val = '0;
    else if (sat) t_val = lt_val[fdc_e];
    else          t_val = dot_q ? int_q : acc_q;
  end

  always_comb begin
    entry_o       = '0;
    entry_o.qty   = want_qty;
    entry_o.mag   = mag_e;
    entry_o.neg   = ill ? 1'b0 : neg_q;
    unique case (want_qty)
      QTY_TIME: begin
        entry_o.mag = t_val;
        if (!ill) begin
          entry_o.hi  = sat ? lt_hi[fdc_e]  : b_hi;
          entry_o.mid = sat ? lt_mid[fdc_e] : b_mid;
          entry_o.lo  = sat ? lt_lo[fdc_e]  : b_lo;
        end
      end
      QTY_DATE: begin
        if (!ill) begin
          entry_o.hi  = sat ? lt_hi[0]  : b_hi;
          entry_o.mid = sat ? lt_mid[0] : b_mid;
          entry_o.lo  = sat ? lt_lo[0]  : b_lo;
        end
      end
      QTY_LAT, QTY_LON: entry_o.scale = 3'd7 - fdc_e[2:0];
      QTY_NS, QTY_EW: begin
        entry_o.mag = MagW'((ffc_q != 8'd0) ? ffc_q : byte_i);
        entry_o.neg = 1'b0;
      end
      QTY_FIX: begin
        entry_o.neg = 1'b0;
        if (ill || neg_q ||
            !(acc_q == MagW'(1) || acc_q == MagW'(4) || acc_q == MagW'(5))) begin
          entry_o.mag = '0;
        end
      end
      QTY_HEADING: entry_o.frac = fdc_e[2:0];
      default: ;
    endcase
  end

  assign fin    = valid_i && (hdr_q == HdrActive) && (byte_i != "$") &&
                  ((byte_i == ",") || term);
  assign push_o = fin && want_v;

  always_comb begin
    logic       clr;
    logic       idle;
    logic       dig_acc;
    hdr_d   = hdr_q;
    kind_d  = kind_q;
    field_d = field_q;
    acc_d   = acc_q;
    int_d   = int_q;
    fdc_d   = fdc_q;
    neg_d   = neg_q;
    dot_d   = dot_q;
    ill_d   = ill_q;
    ffc_d   = ffc_q;
    bcd_d   = bcd_q;
    big_d   = big_q;
    clr     = 1'b0;
    idle    = 1'b0;
    dig_acc = 1'b0;
    if (valid_i) begin
      if (byte_i == "$") begin
        idle  = 1'b1;
        hdr_d = HdrFirst;
      end else if (hdr_q == HdrIdle) begin
        hdr_d = hdr_q;
      end else if (hdr_q < HdrActive) begin
        if (term || !ok) begin
          idle = 1'b1;
        end else begin
          if (hdr_q == HdrKind) begin
            kind_d = (byte_i == "R") ? KIND_RMC : (byte_i == "G") ? KIND_GGA : KIND_TRA;
          end
          hdr_d = hdr_q + 3'd1;
          if (hdr_q + 3'd1 == HdrActive) begin
            field_d = '0;
            clr     = 1'b1;
          end
        end
      end else if (byte_i == ",") begin
        if (field_q != 5'd31) field_d = field_q + 5'd1;
        clr = 1'b1;
      end else if (term) begin
        idle = 1'b1;
      end else if (field_q != 5'd0) begin
        if (ffc_q == 8'd0) ffc_d = byte_i;
        if (byte_i == "-") begin
          neg_d = 1'b1;
        end else if (byte_i == ".") begin
          if (dot_q) ill_d = 1'b1;
          else       int_d = acc_q;
          dot_d = 1'b1;
        end else if (byte_i >= "0" && byte_i <= "9") begin
          if (!dot_q) begin
            dig_acc = 1'b1;
          end else if (fdc_q < cap) begin
            dig_acc = 1'b1;
            fdc_d   = fdc_q + 4'd1;
          end
        end else begin
          ill_d = 1'b1;
        end
      end
      if (dig_acc) begin
        acc_d = sat_mac10(acc_q, byte_i[3:0], Lim);
        // Keep the last six decimal digits for the time and date split.
        if (!dot_q || want_qty == QTY_DATE) begin
          big_d = big_q || (bcd_q[23:20] != 4'd0);
          bcd_d = {bcd_q[19:0], byte_i[3:0]};
        end
      end
      if (idle) begin
        // A '$' restarts header matching straight away.
        hdr_d   = (byte_i == "$") ? HdrFirst : HdrIdle;
        kind_d  = KIND_NONE;
        field_d = '0;
        clr     = 1'b1;
      end
      if (clr) begin
        acc_d = '0;
        fdc_d = '0;
        neg_d = 1'b0;
        dot_d = 1'b0;
        ill_d = 1'b0;
        ffc_d = '0;
        bcd_d = '0;
        big_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HdrIdle;
      kind_q  <= KIND_NONE;
      field_q <= '0;
      acc_q   <= '0;
      fdc_q   <= '0;
      neg_q   <= 1'b0;
      dot_q   <= 1'b0;
      ill_q   <= 1'b0;
      ffc_q   <= '0;
      bcd_q   <= '0;
      big_q   <= 1'b0;
    end else begin
      hdr_q   <= hdr_d;
      kind_q  <= kind_d;
      field_q <= field_d;
      acc_q   <= acc_d;
      fdc_q   <= fdc_d;
      neg_q   <= neg_d;
      dot_q   <= dot_d;
      ill_q   <= ill_d;
      ffc_q   <= ffc_d;
      bcd_q   <= bcd_d;
      big_q   <= big_d;
    end
  end

  always_ff @(posedge clk_i) begin
    int_q <= int_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/nsfp_queue.sv
// Short request queue between the front and the back.
`default_nettype none
module nsfp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  nsfp_pkg::entry_t      wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic                  valid_o,
  output nsfp_pkg::entry_t      rd_data_o
);
  import nsfp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + PtrW'(1);
      if (do_rd) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/nsfp_back.sv
// Back end: scales latitude and longitude, applies the sign, holds the result.
`default_nettype none
module nsfp_back #(
  parameter int unsigned VALUE_BITS = nsfp_pkg::ValueBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  input  nsfp_pkg::entry_t           req_i,
  output logic                       req_take_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic [2:0]                 quantity_o,
  output logic [VALUE_BITS-1:0]      value_o,
  output logic [2:0]                 fraction_digits_o,
  output logic [6:0]                 part_high_o,
  output logic [6:0]                 part_mid_o,
  output logic [6:0]                 part_low_o
);
  import nsfp_pkg::*;

  localparam logic [MagW-1:0] Lim = value_limit(VALUE_BITS);

  entry_t                w_q;
  logic                  w_v_q;
  logic                  out_v_q;
  logic                  w_done, w_move;
  logic [VALUE_BITS-1:0] mag_ext;

  assign w_done     = w_v_q && (w_q.scale == 3'd0);
  assign w_move     = w_done && (!out_v_q || pop_i);
  assign req_take_o = !w_v_q || w_move;
  assign empty_o    = !out_v_q;
  assign mag_ext    = VALUE_BITS'(w_q.mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (req_take_o) w_v_q <= req_valid_i;
      if (w_move)     out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      w_q <= req_i;
    end else if (w_v_q && w_q.scale != 3'd0) begin
      // One decimal place a cycle until seven fraction digits are reached.
      w_q.mag   <= sat_mac10(w_q.mag, 4'd0, Lim);
      w_q.scale <= w_q.scale - 3'd1;
    end
    if (w_move) begin
      quantity_o        <= w_q.qty;
      value_o           <= w_q.neg ? (VALUE_BITS'(0) - mag_ext) : mag_ext;
      fraction_digits_o <= w_q.frac;
      part_high_o       <= w_q.hi;
      part_mid_o        <= w_q.mid;
      part_low_o        <= w_q.lo;
    end
  end

endmodule
`default_nettype wire

>>> sim/nmea_sentence_field_parser_tb.sv
// Self-checking testbench for the NMEA sentence field parser: directed and random byte streams.
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_field_parser_tb;
  import nsfp_pkg::*;

  localparam int unsigned FracMax = 7;
  localparam int unsigned VBits   = 41;
  localparam longint unsigned Mask41 = 64'h1FF_FFFF_FFFF;
  localparam longint unsigned ValLim = 64'd999999999999;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [2:0]  qty;
    logic [40:0] value;
    logic [2:0]  frac;
    logic [6:0]  hi;
    logic [6:0]  mid;
    logic [6:0]  lo;
  } field_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] text_byte_i = 8'h00;
  logic full, empty;
  logic [2:0] quantity_o, fraction_digits_o;
  logic [VBits-1:0] value_o;
  logic [6:0] part_high_o, part_mid_o, part_low_o;

  nmea_sentence_field_parser DUT (
    .clk_i, .rst_ni, .push, .full, .text_byte_i, .empty, .pop,
    .quantity_o, .value_o, .fraction_digits_o, .part_high_o, .part_mid_o, .part_low_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser state mirror
  int unsigned hdr_pos;
  kind_e kind;
  int unsigned fld_idx;
  longint unsigned acc;
  int unsigned int_cnt, frac_cnt;
  bit f_neg, f_dot, f_bad;
  byte unsigned first_ch;

  field_res_t expected_fields[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;

  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned r;
    r = 1;
    repeat (n) r *= 10;
    return r;
  endfunction

  function automatic longint unsigned sat_mul_add(longint unsigned a, longint unsigned m,
                                                  longint unsigned add);
    if (a > ValLim) a = ValLim;
    if (add > ValLim) return ValLim;
    if (m != 0 && a > (ValLim - add) / m) return ValLim;
    return a * m + add;
  endfunction

  function automatic void clear_field();
    acc = 0; int_cnt = 0; frac_cnt = 0;
    f_neg = 0; f_dot = 0; f_bad = 0; first_ch = 0;
  endfunction

  function automatic void go_idle();
    hdr_pos = 0; kind = KIND_NONE; fld_idx = 0;
    clear_field();
  endfunction

  function automatic int wanted_qty();
    case (kind)
      KIND_RMC: begin
        if (fld_idx == 1) return QTY_TIME;
        if (fld_idx == 9) return QTY_DATE;
      end
      KIND_GGA: if (fld_idx >= 2 && fld_idx <= 6) return fld_idx;
      KIND_TRA: if (fld_idx == 2) return QTY_HEADING;
      default: ;
    endcase
    return -1;
  endfunction

  function automatic void close_field(byte unsigned endb, bit bad_end);
    int q;
    longint unsigned mag, t, val, hi, mid, lo, fd;
    bit neg;
    field_res_t r;
    q = wanted_qty();
    if (q < 0) return;
    if (bad_end) f_bad = 1;
    neg = f_neg;
    mag = acc;
    hi = 0; mid = 0; lo = 0; fd = 0;
    if (f_bad) begin
      mag = 0; neg = 0; frac_cnt = 0;
    end
    val = neg ? ((0 - mag) & Mask41) : mag;
    case (q)
      QTY_TIME: begin
        t = mag / pow10(frac_cnt);
        val = neg ? ((0 - t) & Mask41) : t;
        hi = t / 10000; if (hi > 99) hi = 99;
        mid = (t / 100) % 100; lo = t % 100;
      end
      QTY_DATE: begin
        hi = mag / 10000; if (hi > 99) hi = 99;
        mid = (mag / 100) % 100; lo = mag % 100;
      end
      QTY_LAT, QTY_LON: begin
        t = sat_mul_add(mag, pow10(7 - (frac_cnt & 7)), 0);
        val = neg ? ((0 - t) & Mask41) : t;
      end
      QTY_NS, QTY_EW: val = (first_ch != 0) ? first_ch : endb;
      QTY_FIX: val = (!neg && (mag == 1 || mag == 4 || mag == 5)) ? mag : 0;
      default: fd = frac_cnt & 7;
    endcase
    r.qty = q[2:0]; r.value = val[40:0]; r.frac = fd[2:0];
    r.hi = hi[6:0]; r.mid = mid[6:0]; r.lo = lo[6:0];
    expected_fields.push_back(r);
  endfunction

  function automatic void take_char(byte unsigned b);
    int q;
    int unsigned cap;
    if (first_ch == 0) first_ch = b;
    if (b == "-") f_neg = 1;
    else if (b == ".") begin
      if (f_dot) f_bad = 1;
      f_dot = 1;
    end else if (b >= "0" && b <= "9") begin
      q = wanted_qty();
      cap = (q == QTY_LAT || q == QTY_LON) ? 7 : FracMax;
      if (!f_dot) begin
        acc = sat_mul_add(acc, 10, b - "0");
        if (int_cnt < 15) int_cnt++;
      end else if (frac_cnt < cap) begin
        acc = sat_mul_add(acc, 10, b - "0");
        frac_cnt++;
      end
    end else f_bad = 1;
  endfunction

  function automatic void predict_byte(byte unsigned b);
    bit term, ok;
    term = (b == "*") || (b < 8'h20) || (b > "z");
    if (b == "$") begin
      go_idle(); hdr_pos = 1; return;
    end
    if (hdr_pos == 0) return;
    if (hdr_pos < 6) begin
      ok = 0;
      if (term) begin
        go_idle(); return;
      end
      case (hdr_pos)
        1: ok = (b == "G");
        2: ok = (b == "P");
        3: begin
          if (b == "R") begin kind = KIND_RMC; ok = 1; end
          else if (b == "G") begin kind = KIND_GGA; ok = 1; end
          else if (b == "T") begin kind = KIND_TRA; ok = 1; end
        end
        4: ok = (kind == KIND_RMC && b == "M") || (kind == KIND_GGA && b == "G") ||
                (kind == KIND_TRA && b == "R");
        default: ok = (kind == KIND_RMC && b == "C") || (kind != KIND_NONE &&
                      kind != KIND_RMC && b == "A");
      endcase
      if (!ok) begin
        go_idle(); return;
      end
      hdr_pos++;
      if (hdr_pos == 6) begin
        fld_idx = 0; clear_field();
      end
      return;
    end
    if (b == ",") begin
      close_field(b, 0);
      if (fld_idx < 31) fld_idx++;
      clear_field();
      return;
    end
    if (term) begin
      close_field(b, b != "*");
      go_idle();
      return;
    end
    if (fld_idx != 0) take_char(b);
  endfunction

  // send one byte; the sender may idle first, push stays high until the next idle
  task automatic send_byte(byte unsigned b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // result checker
  always @(posedge clk_i) begin
    field_res_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result qty=%0d value=%0h", $time, quantity_o, value_o);
        errors++;
      end else begin
        e = expected_fields.pop_front();
        if (e.qty !== quantity_o || e.value !== value_o || e.frac !== fraction_digits_o ||
            e.hi !== part_high_o || e.mid !== part_mid_o || e.lo !== part_low_o) begin
          $display("%0t: mismatch exp q=%0d v=%0h f=%0d %0d:%0d:%0d got q=%0d v=%0h f=%0d %0d:%0d:%0d",
                   $time, e.qty, e.value, e.frac, e.hi, e.mid, e.lo, quantity_o, value_o,
                   fraction_digits_o, part_high_o, part_mid_o, part_low_o);
          errors++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** nmea_sentence_field_parser: FAILED **");
      $finish;
    end
  end

  function automatic string rand_digits(int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, string'(byte'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_number();
    string s;
    s = "";
    if ($urandom_range(9) == 0) s = "-";
    s = {s, rand_digits($urandom_range(5))};
    if ($urandom_range(3) != 0) s = {s, ".", rand_digits($urandom_range(9))};
    if ($urandom_range(19) == 0) s = {s, string'(byte'($urandom_range(33, 122)))};
    return s;
  endfunction

  function automatic string rand_sentence();
    string s;
    int unsigned nf;
    case ($urandom_range(2))
      0: s = "$GPRMC";
      1: s = "$GPGGA";
      default: s = "$GPTRA";
    endcase
    nf = $urandom_range(3, 13);
    for (int i = 0; i < nf; i++) begin
      case ($urandom_range(5))
        0: s = {s, ",", string'(byte'("A" + $urandom_range(25)))};
        1: s = {s, ","};
        2: s = {s, ",", rand_digits(6), ".", rand_digits(2)};
        default: s = {s, ",", rand_number()};
      endcase
    end
    case ($urandom_range(3))
      0: s = {s, "\r\n"};
      1: s = {s, string'(byte'($urandom_range(123, 255)))};
      default: s = {s, "*", rand_digits(2)};
    endcase
    return s;
  endfunction

  // drop push and hold until every expected result has come
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_text("$GPRMC,123519.25,A,4807.038,N,01131.000,E,022.4,084.4,230394,,*6A\r\n");
    send_text("$GPGGA,x,-4807.0381234567,S,99999999999999.9,,4,08,0.9*47\n");
    send_text("$GPGGA,,1.2.3,n,-01131,W,5,,\x00$GPGGA,,,,,,7,");
    send_text("$GPTRA,1,-123.456789012,$GPTRA,1,9.9\xff$GPXYZ,1,2,3\n");
    send_text("$GPRMC,999999999999999,,,,,,,,-311299,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,*");
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_bytes);
    string s;
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end else begin
        s = rand_sentence();
        if ($urandom_range(9) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
        send_text(s);
        sent += s.len();
      end
    end
  endtask

  task automatic test_hold_off();
    send_text("$GPGGA,1,2.5,N,3.25,E,1,");
    wait_drained();
    send_text("$GPTRA,0,359.99*\n");
  endtask

  initial begin
    go_idle();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 15; recv_idle_pct = 78;
    test_directed();
    test_random(380);
    test_hold_off();
    send_idle_pct = 78; recv_idle_pct = 15;
    test_random(380);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(380);
    wait_drained();
    if (errors == 0) $display("** nmea_sentence_field_parser: PASSED **");
    else $display("** nmea_sentence_field_parser: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/nsfp_pkg.sv
rtl/core/nsfp_front.sv
rtl/core/nsfp_queue.sv
rtl/core/nsfp_back.sv
rtl/core/nmea_sentence_field_parser.sv
sim/nmea_sentence_field_parser_tb.sv
